### src/ncr_utf8_pkg.sv
// Shared types, character codes and the UTF-8 encoder for the numeric
// character reference decoder. Used by the parser and the top level.
`timescale 1ns / 1ps

package ncr_utf8_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned MaxOut = 4;
  localparam int unsigned CountW = 3;

  localparam logic [ByteW-1:0] AMP_CHAR   = 8'h26;  // '&'
  localparam logic [ByteW-1:0] HASH_CHAR  = 8'h23;  // '#'
  localparam logic [ByteW-1:0] SEMI_CHAR  = 8'h3B;  // ';'
  localparam logic [ByteW-1:0] ZERO_CHAR  = 8'h30;  // '0'
  localparam logic [ByteW-1:0] NINE_CHAR  = 8'h39;  // '9'

  localparam logic [CodeW-1:0] CODE_MAX   = 21'h1FFFFF;
  localparam logic [CodeW-1:0] LIMIT_2B   = 21'h000080;
  localparam logic [CodeW-1:0] LIMIT_3B   = 21'h000800;
  localparam logic [CodeW-1:0] LIMIT_4B   = 21'h010000;

  localparam logic [ByteW-1:0] LEAD_2B    = 8'hC0;
  localparam logic [ByteW-1:0] LEAD_3B    = 8'hE0;
  localparam logic [ByteW-1:0] LEAD_4B    = 8'hF0;
  localparam logic [ByteW-1:0] CONT_MARK  = 8'h80;

  // Parser modes, one-hot.
  typedef enum logic [3:0] {
    MODE_PLAIN  = 4'b0001,
    MODE_AMP    = 4'b0010,
    MODE_DIGITS = 4'b0100,
    MODE_SKIP   = 4'b1000
  } mode_t;

  // Bytes produced by one input transaction, first byte in entry 0.
  typedef struct packed {
    logic [CountW-1:0]              count;
    logic [MaxOut-1:0][ByteW-1:0]   bytes;
  } emit_t;

  // Encode a code value as UTF-8; a value of zero gives no bytes.
  function automatic emit_t utf8_encode(input logic [CodeW-1:0] c);
    emit_t e;
    e = '0;
    priority if (c == '0) begin
      e.count = 3'd0;
    end else if (c < LIMIT_2B) begin
      e.count    = 3'd1;
      e.bytes[0] = {1'b0, c[6:0]};
    end else if (c < LIMIT_3B) begin
      e.count    = 3'd2;
      e.bytes[0] = LEAD_2B | {3'b000, c[10:6]};
      e.bytes[1] = CONT_MARK | {2'b00, c[5:0]};
    end else if (c < LIMIT_4B) begin
      e.count    = 3'd3;
      e.bytes[0] = LEAD_3B | {4'b0000, c[15:12]};
      e.bytes[1] = CONT_MARK | {2'b00, c[11:6]};
      e.bytes[2] = CONT_MARK | {2'b00, c[5:0]};
    end else begin
      e.count    = 3'd4;
      e.bytes[0] = LEAD_4B | {5'b00000, c[20:18]};
      e.bytes[1] = CONT_MARK | {2'b00, c[17:12]};
      e.bytes[2] = CONT_MARK | {2'b00, c[11:6]};
      e.bytes[3] = CONT_MARK | {2'b00, c[5:0]};
    end
    return e;
  endfunction

endpackage

### src/ncr_utf8_parse.sv
// Character reference parser: holds the parse mode and the decimal accumulator
// and works out the bytes that each accepted text byte produces. Uses ncr_utf8_pkg.
`timescale 1ns / 1ps

module ncr_utf8_parse (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [ncr_utf8_pkg::ByteW-1:0] in_byte,
  input  logic                        in_last,
  output ncr_utf8_pkg::emit_t         emit
);

  ncr_utf8_pkg::mode_t                  mode, mode_next;
  logic [ncr_utf8_pkg::CodeW-1:0]       code, code_next;
  logic [ncr_utf8_pkg::CodeW+3:0]       code_x10;
  logic                                 is_digit;

  // Accumulator step: code * 10 + digit, saturating.
  assign is_digit = (in_byte >= ncr_utf8_pkg::ZERO_CHAR) &&
                    (in_byte <= ncr_utf8_pkg::NINE_CHAR);
  assign code_x10 = {1'b0, code, 3'b000} + {3'b000, code, 1'b0} +
                    {{(ncr_utf8_pkg::CodeW){1'b0}}, in_byte[3:0]};

  // Next state and produced bytes for the byte on the input.
  always_comb begin
    mode_next = mode;
    code_next = code;
    emit      = '0;
    unique case (mode)
      ncr_utf8_pkg::MODE_PLAIN: begin
        if (in_byte == ncr_utf8_pkg::AMP_CHAR) begin
          mode_next = ncr_utf8_pkg::MODE_AMP;
        end else begin
          emit.count    = 3'd1;
          emit.bytes[0] = in_byte;
        end
      end
      ncr_utf8_pkg::MODE_AMP: begin
        if (in_byte == ncr_utf8_pkg::HASH_CHAR) begin
          mode_next = ncr_utf8_pkg::MODE_DIGITS;
          code_next = '0;
        end else if (in_byte == ncr_utf8_pkg::AMP_CHAR) begin
          emit.count    = 3'd1;
          emit.bytes[0] = ncr_utf8_pkg::AMP_CHAR;
        end else begin
          emit.count    = 3'd2;
          emit.bytes[0] = ncr_utf8_pkg::AMP_CHAR;
          emit.bytes[1] = in_byte;
          mode_next     = ncr_utf8_pkg::MODE_PLAIN;
        end
      end
      ncr_utf8_pkg::MODE_DIGITS: begin
        if (is_digit) begin
          if (code_x10 > {4'b0000, ncr_utf8_pkg::CODE_MAX}) begin
            code_next = ncr_utf8_pkg::CODE_MAX;
          end else begin
            code_next = code_x10[ncr_utf8_pkg::CodeW-1:0];
          end
        end else if (in_byte == ncr_utf8_pkg::SEMI_CHAR) begin
          emit      = ncr_utf8_pkg::utf8_encode(code);
          mode_next = ncr_utf8_pkg::MODE_PLAIN;
          code_next = '0;
        end else begin
          mode_next = ncr_utf8_pkg::MODE_SKIP;
        end
      end
      ncr_utf8_pkg::MODE_SKIP: begin
        if (in_byte == ncr_utf8_pkg::SEMI_CHAR) begin
          emit      = ncr_utf8_pkg::utf8_encode(code);
          mode_next = ncr_utf8_pkg::MODE_PLAIN;
          code_next = '0;
        end
      end
      default: begin
        mode_next = ncr_utf8_pkg::MODE_PLAIN;
        code_next = '0;
      end
    endcase

    // End of text flushes a held '&' and drops an open reference.
    if (in_last) begin
      if (mode_next == ncr_utf8_pkg::MODE_AMP) begin
        emit.bytes[emit.count[1:0]] = ncr_utf8_pkg::AMP_CHAR;
        emit.count                  = emit.count + 3'd1;
      end
      mode_next = ncr_utf8_pkg::MODE_PLAIN;
      code_next = '0;
    end
  end

  // Parse state registers advance once per accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ncr_utf8_pkg::MODE_PLAIN;
      code <= '0;
    end else if (accept) begin
      mode <= mode_next;
      code <= code_next;
    end
  end

endmodule

### src/numeric_char_ref_to_utf8_core.sv
// Top level of the decimal numeric character reference to UTF-8 decoder.
// Depends on ncr_utf8_pkg and ncr_utf8_parse.
`timescale 1ns / 1ps

// The block takes at most one text byte per cycle and passes ordinary bytes
// through, each on the output in the cycle after it is taken. Each input
// transaction produces zero to four output bytes, held in a four-byte result
// buffer that drains one byte per cycle while the receiver is ready; tlast
// marks the final byte produced by an input byte. A new input byte is taken
// whenever the buffer is empty or its final byte leaves in the same cycle, so
// plain text runs at one byte per cycle while the receiver is ready. An input
// byte that produces more than one byte (as a reference ending in ';' or a
// held '&' released together with the next byte may) holds the input until
// its last byte leaves; bytes that produce nothing leave the input free.

module numeric_char_ref_to_utf8_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // last_of_run
);

  ncr_utf8_pkg::emit_t                                     emit;
  logic [ncr_utf8_pkg::MaxOut-1:0][ncr_utf8_pkg::ByteW-1:0] out_buf;
  logic [ncr_utf8_pkg::CountW-1:0]                         out_cnt;
  logic                                                    accept;
  logic                                                    pop;

  // Handshakes: the input is free once the buffer empties this cycle.
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (out_cnt == 3'd0) || ((out_cnt == 3'd1) && m_tready);
  assign accept   = s_tvalid && s_tready;

  ncr_utf8_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (s_tdata),
    .in_last (s_tlast),
    .emit    (emit)
  );

  // Result buffer: loaded from the parser, shifted out a byte at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= '0;
    end else if (accept) begin
      out_cnt <= emit.count;
    end else if (pop) begin
      out_cnt <= out_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_buf <= emit.bytes;
    end else if (pop) begin
      out_buf <= {8'h00, out_buf[ncr_utf8_pkg::MaxOut-1:1]};
    end
  end

  assign m_tvalid = (out_cnt != 3'd0);
  assign m_tdata  = out_buf[0];
  assign m_tlast  = (out_cnt == 3'd1);

endmodule

### src/ncr_utf8_check.sv
// Port-level checker for numeric_char_ref_to_utf8_core, bound to the top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module ncr_utf8_check (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

  // An idle output side never blocks the input.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // No new text byte is taken in the middle of a multi-byte burst.
  a_burst_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken during a burst");

  // A stall on the final byte of a burst blocks the input.
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && !m_tready |-> !s_tready)
    else $error("input taken while final byte stalled");

endmodule

bind numeric_char_ref_to_utf8_core ncr_utf8_check u_ncr_utf8_check (.*);

### sim/tb_numeric_char_ref_to_utf8_core.sv
// Self-checking testbench for numeric_char_ref_to_utf8_core: drives text bytes on the
// input stream and checks every decoded byte against a behavioral decoder model, or against typed-in bytes.
// Depends on ncr_utf8_pkg and the RTL of the decoder.
`timescale 1ns / 1ps

module tb_numeric_char_ref_to_utf8_core;
  import ncr_utf8_pkg::*;

  // One input byte, with its expected output typed in where it is obvious.
  typedef struct {
    logic [7:0]      text;
    logic            eot;
    bit              typed;
    int              n;
    logic [3:0][7:0] bytes;  // bytes[0] goes out first
  } text_item_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       last;
  } decoded_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] text_byte
  logic       s_tlast = 1'b0;    // end_of_text
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tlast;           // last_of_run

  text_item_t    offered_items[$];
  decoded_byte_t expected_bytes[$];
  int unsigned   error_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   src_idle_pct = 0;
  int unsigned   snk_idle_pct = 0;
  int unsigned   hold_cycles = 0;

  // Decoder model state.
  mode_t            dec_mode = MODE_PLAIN;
  logic [CodeW-1:0] dec_code = '0;

  numeric_char_ref_to_utf8_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  task automatic flag_error(input string msg);
    if (error_count < 40) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic text_item_t tbl_row(input logic [7:0] text, input logic eot,
                                         input int typed, input int n,
                                         input logic [31:0] bytes);
    text_item_t it;
    it.text  = text;
    it.eot   = eot;
    it.typed = (typed != 0);
    it.n     = n;
    it.bytes = bytes;
    return it;
  endfunction

  // Advance the decoder model by one text byte and return the bytes it emits.
  function automatic int decode_text_byte(input logic [7:0] b, input logic eot,
                                          output logic [3:0][7:0] emitted);
    int               n;
    int unsigned      acc;
    logic [CodeW-1:0] c;
    n = 0;
    emitted = '0;
    case (dec_mode)
      MODE_PLAIN: begin
        if (b == AMP_CHAR) begin
          dec_mode = MODE_AMP;
        end else begin
          emitted[0] = b;
          n = 1;
        end
      end
      MODE_AMP: begin
        if (b == HASH_CHAR) begin
          dec_mode = MODE_DIGITS;
          dec_code = '0;
        end else if (b == AMP_CHAR) begin
          emitted[0] = AMP_CHAR;
          n = 1;
        end else begin
          emitted[0] = AMP_CHAR;
          emitted[1] = b;
          n = 2;
          dec_mode = MODE_PLAIN;
        end
      end
      MODE_DIGITS: begin
        if (b >= ZERO_CHAR && b <= NINE_CHAR) begin
          acc = dec_code * 10 + (b - ZERO_CHAR);
          dec_code = (acc > CODE_MAX) ? CODE_MAX : acc[CodeW-1:0];
        end else if (b != SEMI_CHAR) begin
          dec_mode = MODE_SKIP;
        end
      end
      default: begin
      end
    endcase

    // A semicolon closes an open reference and sends its value out as UTF-8.
    if ((dec_mode == MODE_DIGITS || dec_mode == MODE_SKIP) && b == SEMI_CHAR) begin
      c = dec_code;
      if (c == '0) begin
        n = 0;
      end else if (c < LIMIT_2B) begin
        emitted[0] = {1'b0, c[6:0]};
        n = 1;
      end else if (c < LIMIT_3B) begin
        emitted[0] = LEAD_2B | {3'b000, c[10:6]};
        emitted[1] = CONT_MARK | {2'b00, c[5:0]};
        n = 2;
      end else if (c < LIMIT_4B) begin
        emitted[0] = LEAD_3B | {4'b0000, c[15:12]};
        emitted[1] = CONT_MARK | {2'b00, c[11:6]};
        emitted[2] = CONT_MARK | {2'b00, c[5:0]};
        n = 3;
      end else begin
        emitted[0] = LEAD_4B | {5'b00000, c[20:18]};
        emitted[1] = CONT_MARK | {2'b00, c[17:12]};
        emitted[2] = CONT_MARK | {2'b00, c[11:6]};
        emitted[3] = CONT_MARK | {2'b00, c[5:0]};
        n = 4;
      end
      dec_mode = MODE_PLAIN;
      dec_code = '0;
    end

    // End of text flushes a held ampersand and drops an open reference.
    if (eot) begin
      if (dec_mode == MODE_AMP) begin
        emitted[n] = AMP_CHAR;
        n++;
      end
      dec_mode = MODE_PLAIN;
      dec_code = '0;
    end
    return n;
  endfunction

  // Offer one text byte, with random idle cycles before it, until it is taken.
  task automatic offer_text_byte(input text_item_t it);
    offered_items.push_back(it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it.text;
    s_tlast  <= it.eot;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Receiver: random back-pressure, plus long hold-offs when requested.
  initial begin : sink_proc
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Check each output transaction, then record what an accepted input should yield.
  always @(posedge clk) begin : scoreboard
    text_item_t      it;
    logic [3:0][7:0] got;
    int              n;
    decoded_byte_t   exp;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          flag_error($sformatf("unexpected output byte %h last %b", m_tdata, m_tlast));
        end else begin
          exp = expected_bytes.pop_front();
          if (m_tdata !== exp.out_byte) begin
            flag_error($sformatf("out_byte %h, expected %h", m_tdata, exp.out_byte));
          end
          if (m_tlast !== exp.last) begin
            flag_error($sformatf("last_of_run %b, expected %b (byte %h)",
                                 m_tlast, exp.last, exp.out_byte));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        it = offered_items.pop_front();
        n = decode_text_byte(s_tdata, s_tlast, got);
        if (it.typed) begin
          n   = it.n;
          got = it.bytes;
        end
        for (int k = 0; k < n; k++) begin
          expected_bytes.push_back('{got[k], (k == n - 1)});
        end
      end
    end
  end

  initial begin : stimulus
    text_item_t  directed_tbl[$];
    int unsigned kind;
    int unsigned v;
    int unsigned drain;
    string       digits;
    bit          hold_done;
    logic [7:0]  b;

    // Directed rows; typed bytes are packed with the first output in the low byte.
    directed_tbl.push_back(tbl_row(8'h00, 1'b0, 1, 1, 32'h00));        // zero byte
    directed_tbl.push_back(tbl_row(8'hFF, 1'b0, 1, 1, 32'hFF));
    directed_tbl.push_back(tbl_row(AMP_CHAR, 1'b0, 1, 0, 32'h0));
    directed_tbl.push_back(tbl_row(AMP_CHAR, 1'b0, 1, 1, 32'h26));     // '&' '&'
    directed_tbl.push_back(tbl_row("x", 1'b0, 1, 2, 32'h7826));        // '&' then text
    directed_tbl.push_back(tbl_row(AMP_CHAR, 1'b0, 1, 0, 32'h0));
    directed_tbl.push_back(tbl_row(HASH_CHAR, 1'b0, 1, 0, 32'h0));
    directed_tbl.push_back(tbl_row("-", 1'b0, 1, 0, 32'h0));           // sign
    directed_tbl.push_back(tbl_row("7", 1'b0, 1, 0, 32'h0));           // skipped
    directed_tbl.push_back(tbl_row(SEMI_CHAR, 1'b0, 1, 0, 32'h0));
    directed_tbl.push_back(tbl_row(AMP_CHAR, 1'b0, 1, 0, 32'h0));
    directed_tbl.push_back(tbl_row(HASH_CHAR, 1'b0, 1, 0, 32'h0));
    directed_tbl.push_back(tbl_row(SEMI_CHAR, 1'b0, 1, 0, 32'h0));     // no digits
    directed_tbl.push_back(tbl_row(AMP_CHAR, 1'b0, 1, 0, 32'h0));
    directed_tbl.push_back(tbl_row(HASH_CHAR, 1'b0, 1, 0, 32'h0));
    for (int k = 0; k < 7; k++) begin
      directed_tbl.push_back(tbl_row(NINE_CHAR, 1'b0, 0, 0, 32'h0));
    end
    directed_tbl.push_back(tbl_row(SEMI_CHAR, 1'b0, 1, 4, 32'hBFBFBFF7)); // saturated
    directed_tbl.push_back(tbl_row(AMP_CHAR, 1'b1, 1, 1, 32'h26));     // held '&' at end
    directed_tbl.push_back(tbl_row(AMP_CHAR, 1'b0, 0, 0, 32'h0));
    directed_tbl.push_back(tbl_row(HASH_CHAR, 1'b0, 0, 0, 32'h0));
    directed_tbl.push_back(tbl_row("5", 1'b1, 1, 0, 32'h0));           // open ref dropped

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 33;
    snk_idle_pct = 48;
    foreach (directed_tbl[k]) begin
      offer_text_byte(directed_tbl[k]);
    end

    // Random text: mostly well-formed references, some plain runs and broken ones.
    hold_done = 1'b0;
    while (items_sent < 470) begin
      if (items_sent < 180) begin
        src_idle_pct = 33;
        snk_idle_pct = 48;
      end else if (items_sent < 330) begin
        src_idle_pct = 48;
        snk_idle_pct = 33;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
        if (!hold_done) begin
          hold_cycles = 300;
          hold_done = 1'b1;
        end
      end

      kind = $urandom_range(99);
      if (kind < 55) begin
        case ($urandom_range(5))
          0: v = $urandom_range('h7F, 1);
          1: v = $urandom_range('h7FF, 'h80);
          2: v = $urandom_range('hFFFF, 'h800);
          3: v = $urandom_range('h1FFFFF, 'h10000);
          4: v = $urandom_range(9);
          default: v = $urandom_range(99999999, 2097152);
        endcase
        digits = $sformatf("%0d", v);
        if ($urandom_range(9) == 0) begin
          digits = {"00", digits};
        end
        offer_text_byte(tbl_row(AMP_CHAR, 1'b0, 0, 0, 32'h0));
        offer_text_byte(tbl_row(HASH_CHAR, 1'b0, 0, 0, 32'h0));
        for (int k = 0; k < digits.len(); k++) begin
          offer_text_byte(tbl_row(digits[k], 1'b0, 0, 0, 32'h0));
        end
        // Some references carry trailing junk before the semicolon.
        if ($urandom_range(4) == 0) begin
          for (int k = 0; k <= $urandom_range(2); k++) begin
            b = 8'($urandom_range(255));
            if (b == SEMI_CHAR || (k == 0 && b >= ZERO_CHAR && b <= NINE_CHAR)) begin
              b = " ";
            end
            offer_text_byte(tbl_row(b, 1'b0, 0, 0, 32'h0));
          end
        end
        offer_text_byte(tbl_row(SEMI_CHAR, ($urandom_range(9) == 0), 0, 0, 32'h0));
      end else if (kind < 80) begin
        for (int k = 0; k <= $urandom_range(5); k++) begin
          offer_text_byte(tbl_row(8'($urandom_range(255)), ($urandom_range(19) == 0),
                                  0, 0, 32'h0));
        end
      end else begin
        // Broken sequences: stray '&', references cut by end of text, etc.
        offer_text_byte(tbl_row(AMP_CHAR, ($urandom_range(5) == 0), 0, 0, 32'h0));
        case ($urandom_range(3))
          0: offer_text_byte(tbl_row(8'($urandom_range(255)), 1'($urandom_range(1)),
                                     0, 0, 32'h0));
          1: offer_text_byte(tbl_row(AMP_CHAR, 1'($urandom_range(1)), 0, 0, 32'h0));
          default: begin
            offer_text_byte(tbl_row(HASH_CHAR, ($urandom_range(3) == 0), 0, 0, 32'h0));
            for (int k = 0; k <= $urandom_range(3); k++) begin
              offer_text_byte(tbl_row(8'($urandom_range(NINE_CHAR, ZERO_CHAR)), 1'b0,
                                      0, 0, 32'h0));
            end
            offer_text_byte(tbl_row(8'($urandom_range(255)), 1'b1, 0, 0, 32'h0));
          end
        endcase
      end
    end

    // Drain outstanding results, then watch for stray output a little longer.
    s_tvalid <= 1'b0;
    snk_idle_pct = 0;
    drain = 0;
    while (expected_bytes.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      flag_error($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
    end
    if (error_count == 0) begin
      $display("[numeric_char_ref_to_utf8_core] OK");
    end else begin
      $display("[numeric_char_ref_to_utf8_core] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #2000000;
    $display("[numeric_char_ref_to_utf8_core] ERROR");
    $finish;
  end

endmodule

### filelist.f
src/ncr_utf8_pkg.sv
src/ncr_utf8_parse.sv
src/numeric_char_ref_to_utf8_core.sv
src/ncr_utf8_check.sv
sim/tb_numeric_char_ref_to_utf8_core.sv
